// ===== design/light_bar_pair_plate_corners_macros.svh =====
// assertion macros for the light bar pair plate corner block
`ifndef LIGHT_BAR_PAIR_PLATE_CORNERS_MACROS_SVH
`define LIGHT_BAR_PAIR_PLATE_CORNERS_MACROS_SVH

// property checked while reset is low
`define LBPPC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lbppc assertion failed");

// property checked on every edge, reset included
`define LBPPC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("lbppc assertion failed");

`endif

// ===== design/lbppc_pkg.sv =====
// shared types and constants for the light bar pair plate corner block
package lbppc_pkg;

  localparam int COORD_W         = 16;
  localparam int COORD_FRAC_BITS = 4;
  localparam int MIN_LEN_PX      = 4;
  localparam int MIN_LEN         = MIN_LEN_PX << COORD_FRAC_BITS;
  localparam int LEN_THR2        = MIN_LEN * MIN_LEN;
  localparam int GAP_THR2        = 4 * LEN_THR2;

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_TOP_RATIO    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_RATIO = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
  } bar_t;

  // left bar first, right bar second
  typedef struct packed {
    bar_t lb;
    bar_t rb;
  } pair_t;

  typedef struct packed {
    coord_t ltx;
    coord_t lty;
    coord_t rtx;
    coord_t rty;
    coord_t rbx;
    coord_t rby;
    coord_t lbx;
    coord_t lby;
    logic   ok;
  } plate_t;

endpackage

// ===== design/lbppc_front.sv =====
// front end: holds the first bar and forms ordered pairs
module lbppc_front (
  input  logic              clk,
  input  logic              in_valid,
  output logic              in_ready,
  input  lbppc_pkg::bar_t   bar,
  input  lbppc_pkg::coord_t center,
  input  logic              closes_pair,
  output logic              push_valid,
  input  logic              push_ready,
  output lbppc_pkg::pair_t  push_data
);

  lbppc_pkg::bar_t   held_bar;
  lbppc_pkg::coord_t held_center;

  assign in_ready   = push_ready;
  assign push_valid = in_valid && closes_pair;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && !closes_pair) begin
      held_bar    <= bar;
      held_center <= center;
    end
  end

  // equal centres keep the incoming bar on the left
  always_comb begin
    if (center > held_center) begin
      push_data.lb = held_bar;
      push_data.rb = bar;
    end else begin
      push_data.lb = bar;
      push_data.rb = held_bar;
    end
  end

endmodule

// ===== design/lbppc_queue.sv =====
// short pair queue between front and back
module lbppc_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  lbppc_pkg::pair_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output lbppc_pkg::pair_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lbppc_pkg::pair_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/lbppc_back.sv =====
// back end: edge selection, inward shift and plate check pipeline
module lbppc_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lbppc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lbppc_pkg::COORD_W-1:0]         cfg_data,
  input  logic                                  pair_valid,
  output logic                                  pair_ready,
  input  lbppc_pkg::pair_t                      pair,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output lbppc_pkg::plate_t                     plate
);

  localparam int CW         = lbppc_pkg::COORD_W;
  localparam int DIFF_W     = CW + 1;
  localparam int LEN2_W     = 2 * DIFF_W + 1;
  localparam int PROD_W     = CW + DIFF_W;
  localparam int RATIO_FRAC = 14;
  localparam int RND_HALF   = 1 << (RATIO_FRAC - 1);
  localparam int SHIFT_W    = PROD_W - RATIO_FRAC + 1;
  localparam int SUM_W      = SHIFT_W + 2;
  localparam int GAP_W      = CW + 3;
  localparam int GAP2_W     = 2 * GAP_W + 1;

  function automatic logic signed [SHIFT_W-1:0] round_q14(
    input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] t;
    t = (PROD_W + 1)'(p) + (PROD_W + 1)'(RND_HALF);
    return SHIFT_W'(t >>> RATIO_FRAC);
  endfunction

  function automatic lbppc_pkg::coord_t sat16(input logic signed [SUM_W-1:0] v);
    lbppc_pkg::coord_t cmax;
    lbppc_pkg::coord_t cmin;
    cmax = {1'b0, {(CW - 1){1'b1}}};
    cmin = {1'b1, {(CW - 1){1'b0}}};
    if (v > SUM_W'(cmax)) begin
      return cmax;
    end else if (v < SUM_W'(cmin)) begin
      return cmin;
    end
    return v[CW-1:0];
  endfunction

  logic signed [CW-1:0] top_ratio;
  logic signed [CW-1:0] bottom_ratio;

  logic en;
  logic v1, v2, v3, v4, v5, v6;

  // stage 1: squared edge lengths
  lbppc_pkg::bar_t    s1_bar [2];
  logic [LEN2_W-1:0]  s1_l2  [2][4];
  // stage 2: longest edge
  lbppc_pkg::bar_t    s2_bar [2];
  logic [1:0]         s2_bk  [2];
  // stage 3: inner edge, ordered top to bottom
  lbppc_pkg::coord_t  s3_x0 [2], s3_y0 [2], s3_x1 [2], s3_y1 [2];
  logic signed [DIFF_W-1:0] s3_vx [2], s3_vy [2];
  // stage 4: ratio products
  lbppc_pkg::coord_t  s4_x0 [2], s4_y0 [2], s4_x1 [2], s4_y1 [2];
  logic signed [PROD_W-1:0] s4_ptx [2], s4_pty [2], s4_pbx [2], s4_pby [2];
  // stage 5: moved ends
  lbppc_pkg::coord_t  s5_tx [2], s5_ty [2], s5_bx [2], s5_by [2];
  // stage 6: squared checks
  lbppc_pkg::coord_t  s6_tx [2], s6_ty [2], s6_bx [2], s6_by [2];
  logic [LEN2_W-1:0]  s6_el2 [2];
  logic [GAP2_W-1:0]  s6_gap2;

  lbppc_pkg::bar_t          c1_bar [2];
  logic [LEN2_W-1:0]        c1_l2  [2][4];
  logic signed [DIFF_W-1:0] c1_dx, c1_dy;
  logic [1:0]               c2_bk  [2];
  logic [LEN2_W-1:0]        c2_best;
  logic [LEN2_W:0]          c3_s0, c3_s1;
  logic                     c3_sel;
  logic [1:0]               c3_a, c3_c, c3_top, c3_bot;
  lbppc_pkg::coord_t        c3_x0 [2], c3_y0 [2], c3_x1 [2], c3_y1 [2];
  logic signed [SHIFT_W-1:0] c5_st, c5_sb;
  lbppc_pkg::coord_t        c5_tx [2], c5_ty [2], c5_bx [2], c5_by [2];
  logic signed [DIFF_W-1:0] c6_ex, c6_ey;
  logic [LEN2_W-1:0]        c6_el2 [2];
  logic signed [GAP_W-1:0]  c6_gx, c6_gy;

  assign cfg_ready  = 1'b1;
  assign en         = !out_valid || out_ready;
  assign pair_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_ratio    <= '0;
      bottom_ratio <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lbppc_pkg::REG_TOP_RATIO: begin
          top_ratio <= cfg_data;
        end
        lbppc_pkg::REG_BOTTOM_RATIO: begin
          bottom_ratio <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    c1_bar[0] = pair.lb;
    c1_bar[1] = pair.rb;
    c1_dx = '0;
    c1_dy = '0;
    for (int b = 0; b < 2; b++) begin
      for (int k = 0; k < 4; k++) begin
        c1_dx = DIFF_W'(c1_bar[b].x[2'(k + 1)]) - DIFF_W'(c1_bar[b].x[k]);
        c1_dy = DIFF_W'(c1_bar[b].y[2'(k + 1)]) - DIFF_W'(c1_bar[b].y[k]);
        c1_l2[b][k] = LEN2_W'($unsigned((2 * DIFF_W)'(c1_dx * c1_dx)))
                    + LEN2_W'($unsigned((2 * DIFF_W)'(c1_dy * c1_dy)));
      end
    end
  end

  // first longest edge wins on ties
  always_comb begin
    c2_best = '0;
    for (int b = 0; b < 2; b++) begin
      c2_best  = s1_l2[b][0];
      c2_bk[b] = 2'd0;
      for (int k = 1; k < 4; k++) begin
        if (s1_l2[b][k] > c2_best) begin
          c2_best  = s1_l2[b][k];
          c2_bk[b] = 2'(k);
        end
      end
    end
  end

  // left bar keeps the right-lying edge, right bar the left-lying one
  always_comb begin
    c3_s0  = '0;
    c3_s1  = '0;
    c3_sel = 1'b0;
    c3_a   = '0;
    c3_c   = '0;
    c3_top = '0;
    c3_bot = '0;
    for (int b = 0; b < 2; b++) begin
      c3_s0 = (LEN2_W + 1)'(s2_bar[b].x[s2_bk[b]])
            + (LEN2_W + 1)'(s2_bar[b].x[s2_bk[b] + 2'd1]);
      c3_s1 = (LEN2_W + 1)'(s2_bar[b].x[s2_bk[b] + 2'd2])
            + (LEN2_W + 1)'(s2_bar[b].x[s2_bk[b] + 2'd3]);
      if (b == 0) begin
        c3_sel = !($signed(c3_s0) >= $signed(c3_s1));
      end else begin
        c3_sel = !($signed(c3_s0) <= $signed(c3_s1));
      end
      c3_a = s2_bk[b] + {c3_sel, 1'b0};
      c3_c = c3_a + 2'd1;
      if (s2_bar[b].y[c3_a] <= s2_bar[b].y[c3_c]) begin
        c3_top = c3_a;
        c3_bot = c3_c;
      end else begin
        c3_top = c3_c;
        c3_bot = c3_a;
      end
      c3_x0[b] = s2_bar[b].x[c3_top];
      c3_y0[b] = s2_bar[b].y[c3_top];
      c3_x1[b] = s2_bar[b].x[c3_bot];
      c3_y1[b] = s2_bar[b].y[c3_bot];
    end
  end

  always_comb begin
    c5_st = '0;
    c5_sb = '0;
    for (int b = 0; b < 2; b++) begin
      c5_st    = round_q14(s4_ptx[b]);
      c5_sb    = round_q14(s4_pbx[b]);
      c5_tx[b] = sat16(SUM_W'(s4_x0[b]) + SUM_W'(c5_st));
      c5_bx[b] = sat16(SUM_W'(s4_x1[b]) - SUM_W'(c5_sb));
      c5_st    = round_q14(s4_pty[b]);
      c5_sb    = round_q14(s4_pby[b]);
      c5_ty[b] = sat16(SUM_W'(s4_y0[b]) + SUM_W'(c5_st));
      c5_by[b] = sat16(SUM_W'(s4_y1[b]) - SUM_W'(c5_sb));
    end
  end

  always_comb begin
    c6_ex = '0;
    c6_ey = '0;
    for (int b = 0; b < 2; b++) begin
      c6_ex = DIFF_W'(s5_tx[b]) - DIFF_W'(s5_bx[b]);
      c6_ey = DIFF_W'(s5_ty[b]) - DIFF_W'(s5_by[b]);
      c6_el2[b] = LEN2_W'($unsigned((2 * DIFF_W)'(c6_ex * c6_ex)))
                + LEN2_W'($unsigned((2 * DIFF_W)'(c6_ey * c6_ey)));
    end
    c6_gx = (GAP_W'(s5_tx[0]) + GAP_W'(s5_bx[0])) - (GAP_W'(s5_tx[1]) + GAP_W'(s5_bx[1]));
    c6_gy = (GAP_W'(s5_ty[0]) + GAP_W'(s5_by[0])) - (GAP_W'(s5_ty[1]) + GAP_W'(s5_by[1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= pair_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < 2; b++) begin
        s1_bar[b] <= c1_bar[b];
        for (int k = 0; k < 4; k++) begin
          s1_l2[b][k] <= c1_l2[b][k];
        end
        s2_bar[b] <= s1_bar[b];
        s2_bk[b]  <= c2_bk[b];
        s3_x0[b]  <= c3_x0[b];
        s3_y0[b]  <= c3_y0[b];
        s3_x1[b]  <= c3_x1[b];
        s3_y1[b]  <= c3_y1[b];
        s3_vx[b]  <= DIFF_W'(c3_x1[b]) - DIFF_W'(c3_x0[b]);
        s3_vy[b]  <= DIFF_W'(c3_y1[b]) - DIFF_W'(c3_y0[b]);
        s4_x0[b]  <= s3_x0[b];
        s4_y0[b]  <= s3_y0[b];
        s4_x1[b]  <= s3_x1[b];
        s4_y1[b]  <= s3_y1[b];
        s4_ptx[b] <= PROD_W'(top_ratio) * PROD_W'(s3_vx[b]);
        s4_pty[b] <= PROD_W'(top_ratio) * PROD_W'(s3_vy[b]);
        s4_pbx[b] <= PROD_W'(bottom_ratio) * PROD_W'(s3_vx[b]);
        s4_pby[b] <= PROD_W'(bottom_ratio) * PROD_W'(s3_vy[b]);
        s5_tx[b]  <= c5_tx[b];
        s5_ty[b]  <= c5_ty[b];
        s5_bx[b]  <= c5_bx[b];
        s5_by[b]  <= c5_by[b];
        s6_tx[b]  <= s5_tx[b];
        s6_ty[b]  <= s5_ty[b];
        s6_bx[b]  <= s5_bx[b];
        s6_by[b]  <= s5_by[b];
        s6_el2[b] <= c6_el2[b];
      end
      s6_gap2 <= GAP2_W'($unsigned((2 * GAP_W)'(c6_gx * c6_gx)))
               + GAP2_W'($unsigned((2 * GAP_W)'(c6_gy * c6_gy)));
      plate.ltx <= s6_tx[0];
      plate.lty <= s6_ty[0];
      plate.lbx <= s6_bx[0];
      plate.lby <= s6_by[0];
      plate.rtx <= s6_tx[1];
      plate.rty <= s6_ty[1];
      plate.rbx <= s6_bx[1];
      plate.rby <= s6_by[1];
      plate.ok  <= (s6_el2[0] >= LEN2_W'(lbppc_pkg::LEN_THR2))
                && (s6_el2[1] >= LEN2_W'(lbppc_pkg::LEN_THR2))
                && (s6_gap2 >= GAP2_W'(lbppc_pkg::GAP_THR2));
    end
  end

endmodule

// ===== design/light_bar_pair_plate_corners.sv =====
// top level: light bar pair to plate corners
// a pairing transaction is stored in the pair queue and then passes the seven back stages to its result
// throughput: one bar per cycle while the output is not stalled, set by the seven-stage back pipeline and pair queue
// a storing bar gives no result and is absorbed in the cycle it is accepted
// reset clears the ratio registers, queue and pipeline valids; the held bar is not cleared
module light_bar_pair_plate_corners #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lbppc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [15:0]                        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [15:0]                 corner0_x,
  input  logic signed [15:0]                 corner0_y,
  input  logic signed [15:0]                 corner1_x,
  input  logic signed [15:0]                 corner1_y,
  input  logic signed [15:0]                 corner2_x,
  input  logic signed [15:0]                 corner2_y,
  input  logic signed [15:0]                 corner3_x,
  input  logic signed [15:0]                 corner3_y,
  input  logic signed [15:0]                 bar_center_x,
  input  logic                               closes_pair,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 left_top_x,
  output logic signed [15:0]                 left_top_y,
  output logic signed [15:0]                 right_top_x,
  output logic signed [15:0]                 right_top_y,
  output logic signed [15:0]                 right_bottom_x,
  output logic signed [15:0]                 right_bottom_y,
  output logic signed [15:0]                 left_bottom_x,
  output logic signed [15:0]                 left_bottom_y,
  output logic                               plate_ok
);

  lbppc_pkg::bar_t   in_bar;
  lbppc_pkg::pair_t  push_data;
  lbppc_pkg::pair_t  pop_data;
  lbppc_pkg::plate_t plate;
  logic              push_valid;
  logic              push_ready;
  logic              pop_valid;
  logic              pop_ready;

  assign in_bar.x[0] = corner0_x;
  assign in_bar.y[0] = corner0_y;
  assign in_bar.x[1] = corner1_x;
  assign in_bar.y[1] = corner1_y;
  assign in_bar.x[2] = corner2_x;
  assign in_bar.y[2] = corner2_y;
  assign in_bar.x[3] = corner3_x;
  assign in_bar.y[3] = corner3_y;

  lbppc_front u_front (
    .clk         (clk),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .bar         (in_bar),
    .center      (bar_center_x),
    .closes_pair (closes_pair),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  lbppc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lbppc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pair_valid (pop_valid),
    .pair_ready (pop_ready),
    .pair       (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .plate      (plate)
  );

  assign left_top_x     = plate.ltx;
  assign left_top_y     = plate.lty;
  assign right_top_x    = plate.rtx;
  assign right_top_y    = plate.rty;
  assign right_bottom_x = plate.rbx;
  assign right_bottom_y = plate.rby;
  assign left_bottom_x  = plate.lbx;
  assign left_bottom_y  = plate.lby;
  assign plate_ok       = plate.ok;

endmodule

// ===== design/lbppc_checker.sv =====
// port-level checker for the light bar pair plate corner block, with its bind
`include "light_bar_pair_plate_corners_macros.svh"

module lbppc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [15:0]                left_top_x,
  input logic signed [15:0]                left_top_y,
  input logic signed [15:0]                right_top_x,
  input logic signed [15:0]                right_top_y,
  input logic signed [15:0]                right_bottom_x,
  input logic signed [15:0]                right_bottom_y,
  input logic signed [15:0]                left_bottom_x,
  input logic signed [15:0]                left_bottom_y,
  input logic                              plate_ok
);

  // a stalled result holds
  `LBPPC_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(left_top_x) && $stable(right_bottom_y) && $stable(plate_ok))

  // no result straight after reset
  `LBPPC_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !out_valid)

  // an accepted plate has a non-degenerate left edge
  `LBPPC_ASSERT(a_left_edge, clk, rst, out_valid && plate_ok |-> (left_top_x != left_bottom_x) || (left_top_y != left_bottom_y))

  // an accepted plate has a non-degenerate right edge apart from the left one
  `LBPPC_ASSERT(a_right_gap, clk, rst, out_valid && plate_ok |-> ((right_top_x != right_bottom_x) || (right_top_y != right_bottom_y)) && ((left_top_x != right_top_x) || (left_top_y != right_top_y) || (left_bottom_x != right_bottom_x) || (left_bottom_y != right_bottom_y)))

endmodule

bind light_bar_pair_plate_corners lbppc_checker u_lbppc_checker (.*);
